/* sv/multicore_heartbeat_leak_monitor_core_defines.svh */
// Assertion macros shared by the checker of the heartbeat and leak monitor.
`ifndef MULTICORE_HEARTBEAT_LEAK_MONITOR_CORE_DEFINES_SVH
`define MULTICORE_HEARTBEAT_LEAK_MONITOR_CORE_DEFINES_SVH

// Generic clocked property, disabled while reset is asserted.
`define HBLM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Overlapping implication built on the generic form.
`define HBLM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    `HBLM_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

/* sv/hblm_pkg.sv */
package hblm_pkg;

    // Default sizing handed to the top level parameters.
    localparam int MAX_CORES_DEF  = 8;
    localparam int COUNT_BITS_DEF = 32;

    // Command codes carried on the input word.
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam int CPU_W = 6;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ONLINE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_THRESHOLD = 2'd1;
    localparam int ONLINE_W = 4;
    localparam int THRESH_W = 32;
    localparam logic [ONLINE_W-1:0] ONLINE_RESET = 4'd1;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd100;

    // Per-core record layout: six counters side by side, lowest first.
    localparam int FLD_BEATS  = 0;
    localparam int FLD_ALLOCS = 1;
    localparam int FLD_FREES  = 2;
    localparam int FLD_SNAP   = 3;
    localparam int FLD_PREV   = 4;
    localparam int FLD_LEAK   = 5;
    localparam int NUM_FLDS   = 6;

    // Result word widths.
    localparam int CORES_W  = 4;
    localparam int OUT_W    = 32;
    localparam int M_DATA_W = 112;
    localparam int S_DATA_W = 8;

    // Per-core operation applied by the shared update unit.
    typedef struct packed {
        logic inc_beats;
        logic inc_allocs;
        logic inc_frees;
        logic do_sample;
        logic do_clear;
    } alu_ctrl_t;

endpackage

/* sv/multicore_heartbeat_leak_monitor_core.sv */
// Heartbeat watchdog and allocation leak monitor for up to MAX_CORES cores. Each input word
// carries a command (tuser) and a core number (tdata): heartbeat ticks, allocations and frees
// bump that core's live counters, a sample command snapshots every online core, flags cores
// whose heartbeat did not move since the previous sample (from the second sample on), counts
// deadlocks when all of two or more online cores are stalled, and records per-core leaks
// (allocations minus frees, floored at zero) against the leak threshold; a clear command
// zeroes the live allocation and free counts of online cores. Every input word yields exactly
// one result word. The per-core counters live in one single-port-read memory and are walked
// one core per cycle through a shared update unit. After a word is accepted, s_tready stays
// low until the block is idle again: a tick, alloc or free that hits a counted core first reads
// and writes back that core's record, then the walk covers the online cores, clamped to MAX_CORES. A
// finished result sits in an output register, so the next word is taken while it waits for
// m_tready; only when a second result is ready before the first has left does the block hold
// in its last cycle until the output register frees up. Configuration writes are accepted in
// any cycle but must only be issued while the block is idle.
module multicore_heartbeat_leak_monitor_core import hblm_pkg::*; #(
    parameter int MAX_CORES  = MAX_CORES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input words.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [5:0] cpu, [7:6] zero
    input  logic [CMD_W-1:0]      s_tuser,   // [2:0] command

    // Result words.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] stall_seen, [1] leak_seen, [2] deadlock_seen, [6:3] stalled_cores,
    // [10:7] leaking_cores, [42:11] leak_sum, [74:43] stall_total,
    // [106:75] deadlock_total, [111:107] zero
    output logic [M_DATA_W-1:0]   m_tdata,

    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [THRESH_W-1:0]   cfg_data
);

    localparam int IDX_W  = $clog2(MAX_CORES);
    localparam int CNT_W  = $clog2(MAX_CORES + 1);
    localparam int REC_W  = NUM_FLDS * COUNT_BITS;
    localparam int WIDE_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
    localparam logic [6:0] MAX7 = 7'(MAX_CORES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVT_RD,
        ST_EVT_WR,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [CPU_W-1:0]      cpu_reg, cpu_next;
    logic                  check_reg, check_next;
    logic [1:0]            samples_reg, samples_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [COUNT_BITS-1:0] sum_reg, sum_next;
    logic [CORES_W-1:0]    stalled_reg, stalled_next;
    logic [CORES_W-1:0]    leaking_reg, leaking_next;
    logic [COUNT_BITS-1:0] stall_total_reg, stall_total_next;
    logic [COUNT_BITS-1:0] dl_total_reg, dl_total_next;
    logic [ONLINE_W-1:0]   num_online_reg, num_online_next;
    logic [THRESH_W-1:0]   thr_reg, thr_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // Online count clamped to the number of cores that exist.
    logic [6:0]       online7, n7;
    logic [CNT_W-1:0] n_cores;

    assign online7 = {3'b000, num_online_reg};
    assign n7      = (online7 > MAX7) ? MAX7 : online7;
    assign n_cores = n7[CNT_W-1:0];

    // Counter memory and the shared per-core update unit.
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [REC_W-1:0] mem_wdata, mem_rdata;

    alu_ctrl_t             alu_ctrl;
    logic [REC_W-1:0]      alu_out;
    logic                  alu_stall, alu_leak;
    logic [COUNT_BITS-1:0] alu_leak_val;

    hblm_mem #(
        .DEPTH (MAX_CORES),
        .WIDTH (REC_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr   (mem_raddr),
        .rdata   (mem_rdata)
    );

    hblm_alu #(
        .COUNT_BITS (COUNT_BITS)
    ) u_alu (
        .ctrl      (alu_ctrl),
        .entry_in  (mem_rdata),
        .thresh    (thr_reg),
        .entry_out (alu_out),
        .stall_hit (alu_stall),
        .leak_hit  (alu_leak),
        .leak_val  (alu_leak_val)
    );

    assign mem_wdata = alu_out;

    // Input decode for the word being offered.
    logic [CMD_W-1:0] in_cmd;
    logic [CPU_W-1:0] in_cpu;
    logic [6:0]       in_cpu7;
    logic             in_hit;

    assign in_cmd  = s_tuser;
    assign in_cpu  = s_tdata[CPU_W-1:0];
    assign in_cpu7 = {1'b0, in_cpu};

    // Ticks count for any existing core; allocs and frees only for online ones.
    always_comb begin
        case (in_cmd)
            CMD_TICK:  in_hit = (in_cpu7 < MAX7);
            CMD_ALLOC: in_hit = (in_cpu7 < n7);
            CMD_FREE:  in_hit = (in_cpu7 < n7);
            default:   in_hit = 1'b0;
        endcase
    end

    // Result word assembly, widened or trimmed to 32 bits.
    logic [WIDE_W-1:0]     sum_wide, st_wide, dl_wide;
    logic [COUNT_BITS-1:0] st_total_upd, dl_total_upd;
    logic                  deadlock;
    logic                  sample_check;

    assign sample_check = (cmd_reg == CMD_SAMPLE) && check_reg;
    assign deadlock     = sample_check && (n7 > 7'd1) && ({3'b000, stalled_reg} == n7);
    assign st_total_upd = sample_check ? stall_total_reg + COUNT_BITS'(stalled_reg)
                                       : stall_total_reg;
    assign dl_total_upd = deadlock ? dl_total_reg + 1'b1 : dl_total_reg;
    assign sum_wide     = WIDE_W'(sum_reg);
    assign st_wide      = WIDE_W'(st_total_upd);
    assign dl_wide      = WIDE_W'(dl_total_upd);

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        cpu_next         = cpu_reg;
        check_next       = check_reg;
        samples_next     = samples_reg;
        rd_idx_next      = rd_idx_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        sum_next         = sum_reg;
        stalled_next     = stalled_reg;
        leaking_next     = leaking_reg;
        stall_total_next = stall_total_reg;
        dl_total_next    = dl_total_reg;
        num_online_next  = num_online_reg;
        thr_next         = thr_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;

        mem_we    = 1'b0;
        mem_waddr = pend_idx_reg;
        mem_raddr = rd_idx_reg[IDX_W-1:0];
        alu_ctrl  = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                REG_NUM_ONLINE:     num_online_next = cfg_data[ONLINE_W-1:0];
                REG_LEAK_THRESHOLD: thr_next        = cfg_data;
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = in_cmd;
                    cpu_next     = in_cpu;
                    rd_idx_next  = '0;
                    pend_next    = 1'b0;
                    sum_next     = '0;
                    stalled_next = '0;
                    leaking_next = '0;
                    if (in_cmd == CMD_SAMPLE) begin
                        // Stall checks start once a previous snapshot exists.
                        check_next = (samples_reg != 2'd0);
                        if (samples_reg != 2'd2) begin
                            samples_next = samples_reg + 2'd1;
                        end
                    end
                    state_next = in_hit ? ST_EVT_RD : ST_WALK;
                end
            end

            ST_EVT_RD: begin
                mem_raddr  = cpu_reg[IDX_W-1:0];
                state_next = ST_EVT_WR;
            end

            ST_EVT_WR: begin
                alu_ctrl.inc_beats  = (cmd_reg == CMD_TICK);
                alu_ctrl.inc_allocs = (cmd_reg == CMD_ALLOC);
                alu_ctrl.inc_frees  = (cmd_reg == CMD_FREE);
                mem_we     = 1'b1;
                mem_waddr  = cpu_reg[IDX_W-1:0];
                state_next = ST_WALK;
            end

            ST_WALK: begin
                // Read of core i overlaps update and write-back of core i - 1.
                alu_ctrl.do_sample = (cmd_reg == CMD_SAMPLE);
                alu_ctrl.do_clear  = (cmd_reg == CMD_CLEAR);
                if (pend_reg) begin
                    mem_we   = alu_ctrl.do_sample || alu_ctrl.do_clear;
                    sum_next = sum_reg + alu_leak_val;
                    if (alu_leak) begin
                        leaking_next = leaking_reg + 1'b1;
                    end
                    if (sample_check && alu_stall) begin
                        stalled_next = stalled_reg + 1'b1;
                    end
                end
                if (rd_idx_reg < n_cores) begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    stall_total_next = st_total_upd;
                    dl_total_next    = dl_total_upd;
                    m_tvalid_next    = 1'b1;
                    m_tdata_next     = {5'b00000,
                                        dl_wide[OUT_W-1:0],
                                        st_wide[OUT_W-1:0],
                                        sum_wide[OUT_W-1:0],
                                        leaking_reg,
                                        stalled_reg,
                                        deadlock,
                                        (leaking_reg != '0),
                                        (stalled_reg != '0)};
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            samples_reg     <= 2'd0;
            check_reg       <= 1'b0;
            pend_reg        <= 1'b0;
            rd_idx_reg      <= '0;
            stall_total_reg <= '0;
            dl_total_reg    <= '0;
            num_online_reg  <= ONLINE_RESET;
            thr_reg         <= THRESH_RESET;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            samples_reg     <= samples_next;
            check_reg       <= check_next;
            pend_reg        <= pend_next;
            rd_idx_reg      <= rd_idx_next;
            stall_total_reg <= stall_total_next;
            dl_total_reg    <= dl_total_next;
            num_online_reg  <= num_online_next;
            thr_reg         <= thr_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        cmd_reg      <= cmd_next;
        cpu_reg      <= cpu_next;
        pend_idx_reg <= pend_idx_next;
        sum_reg      <= sum_next;
        stalled_reg  <= stalled_next;
        leaking_reg  <= leaking_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // Only the core number bits of the input word carry meaning.
    logic unused_tdata;
    assign unused_tdata = ^s_tdata[S_DATA_W-1:CPU_W];

endmodule

/* sv/hblm_mem.sv */
module hblm_mem import hblm_pkg::*; #(
    parameter int DEPTH = MAX_CORES_DEF,
    parameter int WIDTH = NUM_FLDS * COUNT_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;

    // An entry never written reads as zero, which is the reset value of every counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? mem_reg[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

/* sv/hblm_alu.sv */
module hblm_alu import hblm_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  alu_ctrl_t                        ctrl,
    input  logic [NUM_FLDS*COUNT_BITS-1:0]   entry_in,
    input  logic [THRESH_W-1:0]              thresh,
    output logic [NUM_FLDS*COUNT_BITS-1:0]   entry_out,
    output logic                             stall_hit,
    output logic                             leak_hit,
    output logic [COUNT_BITS-1:0]            leak_val
);

    localparam int WIDE_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

    logic [COUNT_BITS-1:0] beats, allocs, frees, snap, prev, leak;
    logic [COUNT_BITS-1:0] leak_new;
    logic [WIDE_W-1:0]     leak_wide, thr_wide;

    assign beats  = entry_in[FLD_BEATS*COUNT_BITS  +: COUNT_BITS];
    assign allocs = entry_in[FLD_ALLOCS*COUNT_BITS +: COUNT_BITS];
    assign frees  = entry_in[FLD_FREES*COUNT_BITS  +: COUNT_BITS];
    assign snap   = entry_in[FLD_SNAP*COUNT_BITS   +: COUNT_BITS];
    assign prev   = entry_in[FLD_PREV*COUNT_BITS   +: COUNT_BITS];
    assign leak   = entry_in[FLD_LEAK*COUNT_BITS   +: COUNT_BITS];

    // Outstanding allocations, floored at zero.
    assign leak_new  = (allocs > frees) ? (allocs - frees) : '0;
    assign leak_wide = WIDE_W'(leak_new);
    assign thr_wide  = WIDE_W'(thresh);

    always_comb begin
        entry_out = entry_in;
        if (ctrl.inc_beats) begin
            entry_out[FLD_BEATS*COUNT_BITS +: COUNT_BITS] = beats + 1'b1;
        end
        if (ctrl.inc_allocs) begin
            entry_out[FLD_ALLOCS*COUNT_BITS +: COUNT_BITS] = allocs + 1'b1;
        end
        if (ctrl.inc_frees) begin
            entry_out[FLD_FREES*COUNT_BITS +: COUNT_BITS] = frees + 1'b1;
        end
        if (ctrl.do_sample) begin
            entry_out[FLD_PREV*COUNT_BITS +: COUNT_BITS] = snap;
            entry_out[FLD_SNAP*COUNT_BITS +: COUNT_BITS] = beats;
            entry_out[FLD_LEAK*COUNT_BITS +: COUNT_BITS] = leak_new;
        end
        if (ctrl.do_clear) begin
            entry_out[FLD_ALLOCS*COUNT_BITS +: COUNT_BITS] = '0;
            entry_out[FLD_FREES*COUNT_BITS  +: COUNT_BITS] = '0;
        end
    end

    // The new snapshot is the live count and the new previous is the old snapshot.
    assign stall_hit = (beats == snap);
    assign leak_hit  = ctrl.do_sample && (leak_wide > thr_wide);
    assign leak_val  = ctrl.do_sample ? leak_new : leak;

    // The previous snapshot is only ever overwritten, never inspected here.
    logic unused_prev;
    assign unused_prev = ^prev;

endmodule

/* sv/hblm_checker.sv */
`include "multicore_heartbeat_leak_monitor_core_defines.svh"

module hblm_checker import hblm_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_DATA_W-1:0]  m_tdata
);

    // A word is not finished when it is accepted, so the block is busy right after accepting one.
    `HBLM_ASSERT(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "input accepted while busy")

    // Summary flags agree with the core counts in the same result word.
    `HBLM_ASSERT_IMP(a_stall_flag, aclk, aresetn, m_tvalid, m_tdata[0] == (m_tdata[6:3] != 4'd0), "stall flag disagrees with stalled count")
    `HBLM_ASSERT_IMP(a_leak_flag, aclk, aresetn, m_tvalid, m_tdata[1] == (m_tdata[10:7] != 4'd0), "leak flag disagrees with leaking count")

    // A deadlock always comes with stalled cores.
    `HBLM_ASSERT_IMP(a_deadlock_stall, aclk, aresetn, m_tvalid && m_tdata[2], m_tdata[0], "deadlock without stalled cores")

endmodule

bind multicore_heartbeat_leak_monitor_core hblm_checker u_hblm_checker (.*);

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hblm_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int CORES      = MAX_CORES_DEF;

    // Command codes past CMD_CLEAR have no effect on the monitor but still answer with a word.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_CLEAR + 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;
    localparam logic [CPU_W-1:0] CPU_TOP       = '1;

    // Index 3 of the configuration channel selects no register.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    // Ready patterns of the result side.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    // One result word split into its fields.
    typedef struct packed {
        logic                stall_seen;
        logic                leak_seen;
        logic                deadlock_seen;
        logic [CORES_W-1:0]  stalled_cores;
        logic [CORES_W-1:0]  leaking_cores;
        logic [OUT_W-1:0]    leak_sum;
        logic [OUT_W-1:0]    stall_total;
        logic [OUT_W-1:0]    deadlock_total;
    } health_report_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [THRESH_W-1:0]   cfg_data;

    multicore_heartbeat_leak_monitor_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state. This mirrors the monitor: per-core live counters,
    // the last two heartbeat snapshots, the stored leak of each core and
    // the running totals, plus our own copy of both registers.
    // ------------------------------------------------------------------
    logic [OUT_W-1:0]     live_beats  [CORES];
    logic [OUT_W-1:0]     live_allocs [CORES];
    logic [OUT_W-1:0]     live_frees  [CORES];
    logic [OUT_W-1:0]     snap_beats  [CORES];
    logic [OUT_W-1:0]     prev_beats  [CORES];
    logic [OUT_W-1:0]     core_leaks  [CORES];
    int unsigned          samples_taken;
    logic [OUT_W-1:0]     stall_sum;
    logic [OUT_W-1:0]     deadlock_sum;
    logic [ONLINE_W-1:0]  online_reg;
    logic [THRESH_W-1:0]  threshold_reg;

    // Reports still owed by the block, oldest first.
    health_report_t pending_reports[$];

    int mismatch_count = 0;

    // Sender burst bookkeeping and the receiver's long hold request.
    int burst_left = 0;
    int hold_request = 0;
    int hold_left = 0;
    int mode_left = 0;
    int unsigned rx_phase = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    function automatic void reset_monitor_model();
        for (int i = 0; i < CORES; i++) begin
            live_beats[i]  = '0;
            live_allocs[i] = '0;
            live_frees[i]  = '0;
            snap_beats[i]  = '0;
            prev_beats[i]  = '0;
            core_leaks[i]  = '0;
        end
        samples_taken = 0;
        stall_sum     = '0;
        deadlock_sum  = '0;
        online_reg    = ONLINE_RESET;
        threshold_reg = THRESH_RESET;
    endfunction

    // The online register is four bits wide; anything above the core count
    // monitors every core.
    function automatic int unsigned online_count();
        return (online_reg > CORES) ? CORES : int'(online_reg);
    endfunction

    // Applies one command to the predictor and returns the report the block
    // must answer with.
    function automatic health_report_t advance_monitor(logic [CMD_W-1:0] cmd,
                                                        logic [CPU_W-1:0] cpu);
        health_report_t rep;
        int unsigned n;
        int unsigned stalled;
        int unsigned leaking;
        logic [OUT_W-1:0] sum;
        rep = '0;
        n = online_count();
        stalled = 0;
        leaking = 0;
        sum = '0;
        case (cmd)
            // Ticks count for any core the block has, online or not.
            CMD_TICK: if (cpu < CORES) live_beats[cpu] += 1'b1;
            CMD_ALLOC: if (cpu < n) live_allocs[cpu] += 1'b1;
            CMD_FREE: if (cpu < n) live_frees[cpu] += 1'b1;
            CMD_SAMPLE: begin
                if (samples_taken < 2) samples_taken++;
                for (int i = 0; i < n; i++) begin
                    prev_beats[i] = snap_beats[i];
                    snap_beats[i] = live_beats[i];
                    core_leaks[i] = (live_allocs[i] > live_frees[i]) ?
                                    live_allocs[i] - live_frees[i] : '0;
                    if (core_leaks[i] > threshold_reg) leaking++;
                end
                // Stall detection needs two snapshots to compare.
                if (samples_taken >= 2) begin
                    for (int i = 0; i < n; i++)
                        if (snap_beats[i] == prev_beats[i]) stalled++;
                    stall_sum += stalled;
                    if (n > 1 && stalled == n) begin
                        rep.deadlock_seen = 1'b1;
                        deadlock_sum += 1'b1;
                    end
                end
            end
            // Clearing leaves the stored leaks alone.
            CMD_CLEAR: begin
                for (int i = 0; i < n; i++) begin
                    live_allocs[i] = '0;
                    live_frees[i]  = '0;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++) sum += core_leaks[i];
        rep.stall_seen     = (stalled > 0);
        rep.leak_seen      = (leaking > 0);
        rep.stalled_cores  = CORES_W'(stalled);
        rep.leaking_cores  = CORES_W'(leaking);
        rep.leak_sum       = sum;
        rep.stall_total    = stall_sum;
        rep.deadlock_total = deadlock_sum;
        return rep;
    endfunction

    function automatic void check_field(string name, logic [OUT_W-1:0] want,
                                        logic [OUT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker. Every word accepted on the master side is unpacked
    // and compared field by field against the oldest outstanding report.
    // Sampling happens at the rising edge, so all values are the ones the
    // block presented during the preceding cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        health_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $error("result word arrived with no report outstanding");
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("stall_seen",     want.stall_seen,     m_tdata[0]);
                check_field("leak_seen",      want.leak_seen,      m_tdata[1]);
                check_field("deadlock_seen",  want.deadlock_seen,  m_tdata[2]);
                check_field("stalled_cores",  want.stalled_cores,  m_tdata[6:3]);
                check_field("leaking_cores",  want.leaking_cores,  m_tdata[10:7]);
                check_field("leak_sum",       want.leak_sum,       m_tdata[42:11]);
                check_field("stall_total",    want.stall_total,    m_tdata[74:43]);
                check_field("deadlock_total", want.deadlock_total, m_tdata[106:75]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side ready. The receiver switches between ready patterns at
    // random, always-ready stretches included. A test can ask for a long
    // hold-off, which this process counts out on its own.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(50, 300);
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            end
            mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_COIN:    m_tready <= $urandom_range(0, 1);
                RX_PATTERN: m_tready <= (rx_phase % 4) != 0;
                default:    m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side. Words go out in bursts of random length separated by
    // random gaps; a gap of zero makes back-to-back bursts. The valid stays
    // high after acceptance so the next word can follow without a bubble,
    // which is why a pause must lower it explicitly.
    // ------------------------------------------------------------------
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [CPU_W-1:0] cpu);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_DATA_W - CPU_W){1'b0}}, cpu};
        do @(posedge aclk); while (!s_tready);
        pending_reports.push_back(advance_monitor(cmd, cpu));
    endtask

    // Stops offering words and waits until every report has come back and
    // the block is surely idle before a register write.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THRESH_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_NUM_ONLINE) online_reg = value[ONLINE_W-1:0];
        else if (idx == REG_LEAK_THRESHOLD) threshold_reg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One random word. Most ticks reach only the cores marked alive; ticks meant
    // for the rest go to core numbers the block does not have and are dropped. A
    // small share goes to random core numbers, so the others usually stall at each sample.
    task automatic send_random_word(logic [CORES-1:0] alive);
        int unsigned roll;
        int unsigned core;
        logic [CMD_W-1:0] cmd;
        logic [CPU_W-1:0] cpu;
        roll = $urandom_range(0, 99);
        core = $urandom_range(0, CORES - 1);
        cpu  = CPU_W'(core);
        if (roll < 40) begin
            cmd = CMD_TICK;
            if (!alive[core]) cpu = CPU_W'($urandom_range(CORES, CPU_TOP));
        end else if (roll < 60) begin
            cmd = CMD_ALLOC;
            if ($urandom_range(0, 7) == 0) cpu = CPU_W'($urandom);
        end else if (roll < 75) begin
            cmd = CMD_FREE;
            if ($urandom_range(0, 7) == 0) cpu = CPU_W'($urandom);
        end else if (roll < 88) begin
            cmd = CMD_SAMPLE;
            cpu = CPU_W'($urandom);
        end else if (roll < 92) begin
            cmd = CMD_CLEAR;
            cpu = CPU_W'($urandom);
        end else if (roll < 95) begin
            cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            cpu = CPU_W'($urandom);
        end else begin
            cmd = CMD_TICK;
            cpu = CPU_W'($urandom);
        end
        send_word(cmd, cpu);
    endtask

    // Reset settings: a single core and the default threshold. The first
    // sample never reports a stall; the second finds the lone core stalled
    // but a single core can never deadlock. Also covers dropped ticks from
    // nonexistent cores, counted ticks from an offline core, ignored allocs
    // from an offline core and the unused command codes.
    task automatic test_single_core();
        send_word(CMD_SAMPLE, 6'd0);
        send_word(CMD_SAMPLE, 6'd0);
        send_word(CMD_TICK, 6'd0);
        send_word(CMD_SAMPLE, 6'd0);
        send_word(CMD_TICK, CPU_TOP);
        send_word(CMD_TICK, 6'd7);
        send_word(CMD_ALLOC, 6'd0);
        send_word(CMD_ALLOC, 6'd0);
        send_word(CMD_FREE, 6'd0);
        send_word(CMD_ALLOC, 6'd5);
        send_word(CMD_UNUSED_LO, 6'd42);
        send_word(CMD_UNUSED_HI, 6'd21);
        send_word(CMD_CLEAR, 6'd0);
    endtask

    // Every core online with a zero threshold: more frees than allocs floor
    // the leak at zero, two samples with no tick between them stall all cores into a
    // deadlock, and a clear keeps the stored leaks until the next sample.
    task automatic test_all_cores_deadlock();
        wait_drained();
        write_reg(REG_NUM_ONLINE, CORES);
        write_reg(REG_LEAK_THRESHOLD, '0);
        send_word(CMD_FREE, 6'd3);
        send_word(CMD_FREE, 6'd3);
        send_word(CMD_ALLOC, 6'd3);
        send_word(CMD_ALLOC, 6'd6);
        send_word(CMD_TICK, 6'd2);
        send_word(CMD_SAMPLE, 6'd0);
        send_word(CMD_SAMPLE, 6'd0);
        send_word(CMD_CLEAR, 6'd0);
        send_word(CMD_SAMPLE, 6'd0);
    endtask

    // No core online, then an online count past the core count with junk in
    // the upper data bits, plus a write to the index that selects nothing.
    task automatic test_online_extremes();
        wait_drained();
        write_reg(REG_NUM_ONLINE, '0);
        write_reg(REG_LEAK_THRESHOLD, '1);
        send_word(CMD_ALLOC, 6'd0);
        send_word(CMD_SAMPLE, 6'd0);
        wait_drained();
        write_reg(REG_NUM_ONLINE, 32'hA5A5_A5AF);
        write_reg(REG_NONE, 32'h0000_0002);
        send_word(CMD_ALLOC, 6'd7);
        send_word(CMD_SAMPLE, 6'd0);
        send_word(CMD_SAMPLE, 6'd0);
    endtask

    // Phases of random traffic, each with fresh register settings and its own
    // set of live cores. Thresholds stay small so leaks actually show up,
    // with the extremes mixed in; an empty live set makes deadlocks likely.
    task automatic test_random_traffic();
        int unsigned roll;
        int unsigned len;
        logic [CORES-1:0] alive;
        logic [THRESH_W-1:0] online_word;
        for (int phase = 0; phase < 12; phase++) begin
            wait_drained();
            roll = $urandom_range(0, 9);
            if (roll == 0) online_word = '0;
            else if (roll == 1) online_word = $urandom_range(CORES + 1, 15);
            else if (roll == 2) online_word = CORES;
            else online_word = $urandom_range(1, CORES);
            if ($urandom_range(0, 3) == 0)
                online_word[THRESH_W-1:ONLINE_W] = $urandom;
            write_reg(REG_NUM_ONLINE, online_word);
            roll = $urandom_range(0, 7);
            if (roll == 0) write_reg(REG_LEAK_THRESHOLD, '0);
            else if (roll == 1) write_reg(REG_LEAK_THRESHOLD, '1);
            else write_reg(REG_LEAK_THRESHOLD, $urandom_range(1, 6));
            roll = $urandom_range(0, 4);
            if (roll == 0) alive = '0;
            else if (roll == 1) alive = '1;
            else alive = CORES'($urandom);
            len = $urandom_range(70, 110);
            repeat (len) send_random_word(alive);
        end
    endtask

    // The receiver holds off for a long stretch while the sender offers words
    // back to back: the output register and the block fill up and the input
    // side must stall until the receiver lets go.
    task automatic test_backpressure();
        wait_drained();
        write_reg(REG_NUM_ONLINE, CORES);
        write_reg(REG_LEAK_THRESHOLD, 32'd1);
        hold_request = 400;
        burst_left = 60;
        repeat (40) send_random_word(CORES'($urandom));
        wait_drained();
    endtask

    // Safety net against a hung handshake.
    initial begin
        #5_000_000;
        $display("multicore_heartbeat_leak_monitor_core test failed");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_monitor_model();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_single_core();
        test_all_cores_deadlock();
        test_online_extremes();
        test_random_traffic();
        test_backpressure();

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("multicore_heartbeat_leak_monitor_core test passed");
        end else begin
            $display("multicore_heartbeat_leak_monitor_core test failed");
        end
        $finish;
    end

endmodule
